/* rtl/sen_pkg.sv */
// Shared types, widths and constants of the equivalent stress block.
package sen_pkg;

  localparam int CW = 32;
  localparam int OW = 32;
  localparam int PW = CW + 5;
  localparam int PP = 2 * PW;
  localparam int RB = CW + 5;
  localparam int FW = 3 * RB + 3;
  localparam int DW = CW + 1;
  localparam int SQ = 2 * DW;
  localparam int QW = 2 * OW;
  localparam int VW = (2 * CW + 6 > QW + 2) ? 2 * CW + 6 : QW + 2;
  localparam int SRW = (2 * RB > QW) ? 2 * RB : QW;
  localparam int FRONT_STAGES = 5;
  localparam int DIV_S = RB + 1;
  localparam logic [63:0] DIV_M64 = ((64'd1 << DIV_S) / 64'd3) + 64'd1;
  localparam logic [DIV_S-2:0] DIV_M = DIV_M64[DIV_S-2:0];

  typedef enum logic {
    CRIT_VON_MISES = 1'b0,
    CRIT_TRESCA    = 1'b1
  } crit_t;

  typedef struct packed {
    logic signed [CW-1:0] stress_xx;
    logic signed [CW-1:0] stress_yy;
    logic signed [CW-1:0] stress_zz;
    logic signed [CW-1:0] shear_xy;
    logic signed [CW-1:0] shear_yz;
    logic signed [CW-1:0] shear_xz;
  } tensor_t;

  typedef struct packed {
    logic [OW-1:0] equivalent_stress;
    logic          saturated;
  } result_t;

  typedef struct packed {
    logic signed [FW-1:0] p_coef;
    logic signed [FW-1:0] d_coef;
    logic signed [FW-1:0] nd_coef;
    logic [QW-1:0]        vm_q;
    logic                 vm_sat;
  } front_t;

  typedef struct packed {
    logic [RB-1:0]        x;
    logic signed [FW-1:0] x2;
    logic signed [FW-1:0] x3;
    logic signed [FW-1:0] px;
    logic signed [FW-1:0] p_coef;
    logic signed [FW-1:0] d_coef;
  } cubic_t;

  typedef struct packed {
    logic [RB-1:0]  r;
    logic [SRW-1:0] r2;
    logic [QW-1:0]  q;
    logic           sat;
  } sqrt_t;

endpackage

/* rtl/sen_front.sv */
// Front pipeline: deviator terms, products and the cubic and square coefficients.
module sen_front import sen_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  tensor_t tin,
  output front_t  fout
);

  logic signed [PW-1:0] p1, q1, r1, u1, v1, w1;
  logic signed [DW-1:0] dab1, dbc1, dca1;
  logic signed [CW-1:0] d1, e1, f1;

  logic signed [PP-1:0] pq2, qr2, pr2, uu2, vv2, ww2, uv2;
  logic signed [PW-1:0] p2, q2, r2, w2;
  logic signed [SQ-1:0] sab2, sbc2, sca2, sdd2, see2, sff2;

  logic signed [FW-1:0] pc3;
  logic signed [PP-1:0] pqr_lo3, pqr_hi3, uvw_lo3, uvw_hi3, pvv_lo3, pvv_hi3;
  logic signed [PP-1:0] qww_lo3, qww_hi3, ruu_lo3, ruu_hi3;
  logic [QW-1:0]        vmq3;
  logic                 vmsat3;
  logic signed [VW-1:0] vm_sum, vm_shear, vm_q2;

  logic signed [FW-1:0] pc4, pqr4, uvw4, pvv4, qww4, ruu4;
  logic [QW-1:0]        vmq4;
  logic                 vmsat4;
  logic signed [FW-1:0] d_sum;

  function automatic logic signed [PP-1:0] mul_lo(logic signed [PP-1:0] a,
                                                  logic signed [PW-1:0] b);
    mul_lo = PP'($signed({1'b0, a[PW-1:0]})) * PP'(b);
  endfunction

  function automatic logic signed [PP-1:0] mul_hi(logic signed [PP-1:0] a,
                                                  logic signed [PW-1:0] b);
    mul_hi = PP'($signed(a[PP-1:PW])) * PP'(b);
  endfunction

  function automatic logic signed [FW-1:0] join_parts(logic signed [PP-1:0] hi,
                                                      logic signed [PP-1:0] lo);
    join_parts = (FW'(hi) <<< PW) + FW'(lo);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= (PW'(tin.stress_xx) <<< 3) - (PW'(tin.stress_yy) <<< 2) - (PW'(tin.stress_zz) <<< 2);
      q1 <= (PW'(tin.stress_yy) <<< 3) - (PW'(tin.stress_xx) <<< 2) - (PW'(tin.stress_zz) <<< 2);
      r1 <= (PW'(tin.stress_zz) <<< 3) - (PW'(tin.stress_xx) <<< 2) - (PW'(tin.stress_yy) <<< 2);
      u1 <= (PW'(tin.shear_xy) <<< 3) + (PW'(tin.shear_xy) <<< 2);
      v1 <= (PW'(tin.shear_yz) <<< 3) + (PW'(tin.shear_yz) <<< 2);
      w1 <= (PW'(tin.shear_xz) <<< 3) + (PW'(tin.shear_xz) <<< 2);
      dab1 <= DW'(tin.stress_xx) - DW'(tin.stress_yy);
      dbc1 <= DW'(tin.stress_yy) - DW'(tin.stress_zz);
      dca1 <= DW'(tin.stress_zz) - DW'(tin.stress_xx);
      d1 <= tin.shear_xy;
      e1 <= tin.shear_yz;
      f1 <= tin.shear_xz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq2 <= PP'(p1) * PP'(q1);
      qr2 <= PP'(q1) * PP'(r1);
      pr2 <= PP'(p1) * PP'(r1);
      uu2 <= PP'(u1) * PP'(u1);
      vv2 <= PP'(v1) * PP'(v1);
      ww2 <= PP'(w1) * PP'(w1);
      uv2 <= PP'(u1) * PP'(v1);
      p2 <= p1;
      q2 <= q1;
      r2 <= r1;
      w2 <= w1;
      sab2 <= SQ'(dab1) * SQ'(dab1);
      sbc2 <= SQ'(dbc1) * SQ'(dbc1);
      sca2 <= SQ'(dca1) * SQ'(dca1);
      sdd2 <= SQ'(d1) * SQ'(d1);
      see2 <= SQ'(e1) * SQ'(e1);
      sff2 <= SQ'(f1) * SQ'(f1);
    end
  end

  always_comb begin
    vm_sum = VW'(sab2) + VW'(sbc2) + VW'(sca2);
    vm_shear = VW'(sdd2) + VW'(see2) + VW'(sff2);
    vm_q2 = vm_sum + (vm_shear <<< 2) + (vm_shear <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc3 <= FW'(uu2) + FW'(vv2) + FW'(ww2) - FW'(pq2) - FW'(qr2) - FW'(pr2);
      pqr_lo3 <= mul_lo(pq2, r2);
      pqr_hi3 <= mul_hi(pq2, r2);
      uvw_lo3 <= mul_lo(uv2, w2);
      uvw_hi3 <= mul_hi(uv2, w2);
      pvv_lo3 <= mul_lo(vv2, p2);
      pvv_hi3 <= mul_hi(vv2, p2);
      qww_lo3 <= mul_lo(ww2, q2);
      qww_hi3 <= mul_hi(ww2, q2);
      ruu_lo3 <= mul_lo(uu2, r2);
      ruu_hi3 <= mul_hi(uu2, r2);
      vmq3 <= vm_q2[QW:1];
      vmsat3 <= |vm_q2[VW-1:QW+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc4 <= pc3;
      pqr4 <= join_parts(pqr_hi3, pqr_lo3);
      uvw4 <= join_parts(uvw_hi3, uvw_lo3);
      pvv4 <= join_parts(pvv_hi3, pvv_lo3);
      qww4 <= join_parts(qww_hi3, qww_lo3);
      ruu4 <= join_parts(ruu_hi3, ruu_lo3);
      vmq4 <= vmq3;
      vmsat4 <= vmsat3;
    end
  end

  assign d_sum = pqr4 + (uvw4 <<< 1) - pvv4 - qww4 - ruu4;

  always_ff @(posedge clk) begin
    if (en) begin
      fout.p_coef <= pc4;
      fout.d_coef <= d_sum;
      fout.nd_coef <= -d_sum;
      fout.vm_q <= vmq4;
      fout.vm_sat <= vmsat4;
    end
  end

endmodule

/* rtl/sen_cubic_cell.sv */
// One bisection cell that decides one bit of the largest root of the cubic.
module sen_cubic_cell import sen_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic   clk,
  input  logic   en,
  input  cubic_t cin,
  output cubic_t cout
);

  localparam logic signed [FW-1:0] ONE = FW'(1);

  logic [RB-1:0]        tx;
  logic signed [FW-1:0] xe, x2s, t2, t3, pt, slope, fv;
  logic                 above;
  cubic_t               cnext;

  always_comb begin
    tx = cin.x | (RB'(1) << BIT);
    xe = $signed(FW'(cin.x));
    x2s = cin.x2 <<< BIT;
    t2 = cin.x2 + (xe <<< (BIT + 1)) + (ONE <<< (2 * BIT));
    t3 = cin.x3 + (x2s <<< 1) + x2s + (xe <<< (2 * BIT + 1)) + (xe <<< (2 * BIT))
         + (ONE <<< (3 * BIT));
    pt = cin.px + (cin.p_coef <<< BIT);
    slope = (t2 <<< 1) + t2 - cin.p_coef;
    fv = t3 - pt - cin.d_coef;
    above = !slope[FW-1] && (|slope) && !fv[FW-1] && (|fv);
    cnext = cin;
    if (!above) begin
      cnext.x = tx;
      cnext.x2 = t2;
      cnext.x3 = t3;
      cnext.px = pt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= cnext;
    end
  end

endmodule

/* rtl/sen_sqrt_cell.sv */
// One cell of the integer square root chain that decides one result bit.
module sen_sqrt_cell import sen_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t cin,
  output sqrt_t cout
);

  logic [RB-1:0]  tr;
  logic [SRW-1:0] t2;
  sqrt_t          cnext;

  always_comb begin
    tr = cin.r | (RB'(1) << BIT);
    t2 = cin.r2 + (SRW'(cin.r) << (BIT + 1)) + (SRW'(1) << (2 * BIT));
    cnext = cin;
    if (t2 <= SRW'(cin.q)) begin
      cnext.r = tr;
      cnext.r2 = t2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= cnext;
    end
  end

endmodule

/* rtl/stress_equivalent_norm_top.sv */
// Top level of the von Mises and Tresca equivalent stress pipeline.
// The tensor channel takes one request of six signed Q16.16 components each cycle
// on tensor_valid and tensor while tensor_stall is low. The result channel gives
// the equivalent stress and a saturation flag on result_valid and result.
// The criterion register is written through cfg_valid and cfg_data; cfg_ready is always
// high. The user must make a write only while no request is in flight; the block does not enforce it.
// The pipeline has five front stages of products, one cell per root bit in a chain
// of 37 bisection cells, and two stages for the divide by twelve and the output
// register. Throughput is one request per cycle while tensor_stall is low.
// The whole pipeline advances together; while a result is held by result_stall,
// tensor_stall is high and every stage keeps its contents.
// Reset clears the criterion to von Mises and empties the pipeline.
module stress_equivalent_norm_top import sen_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    tensor_valid,
  output logic    tensor_stall,
  input  tensor_t tensor,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data
);

  localparam int LAT = FRONT_STAGES + RB + 2;
  localparam int R1_IDX = FRONT_STAGES + RB;

  logic             adv;
  logic [LAT-1:0]   vld;
  crit_t            criterion;
  front_t           front_q;
  cubic_t           hi_s [RB+1];
  cubic_t           lo_s [RB+1];
  sqrt_t            sq_s [RB+1];
  logic [RB:0]      root_sum;
  logic [2*RB-2:0]  prod;
  logic [RB-3:0]    quot;
  logic [RB-1:0]    vm_root;
  logic             vm_sat1;
  logic             tr_sat;

  assign adv = !vld[LAT-1] || !result_stall;
  assign tensor_stall = !adv;
  assign result_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      criterion <= CRIT_VON_MISES;
    end else if (cfg_valid) begin
      criterion <= crit_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], tensor_valid};
    end
  end

  sen_front u_front (
    .clk  (clk),
    .en   (adv),
    .tin  (tensor),
    .fout (front_q)
  );

  always_comb begin
    hi_s[0] = '{x: '0, x2: '0, x3: '0, px: '0,
                p_coef: front_q.p_coef, d_coef: front_q.d_coef};
    lo_s[0] = '{x: '0, x2: '0, x3: '0, px: '0,
                p_coef: front_q.p_coef, d_coef: front_q.nd_coef};
    sq_s[0] = '{r: '0, r2: '0, q: front_q.vm_q, sat: front_q.vm_sat};
  end

  for (genvar j = 0; j < RB; j++) begin : g_cells
    sen_cubic_cell #(.BIT(RB - 1 - j)) u_hi (
      .clk (clk), .en (adv), .cin (hi_s[j]), .cout (hi_s[j+1])
    );
    sen_cubic_cell #(.BIT(RB - 1 - j)) u_lo (
      .clk (clk), .en (adv), .cin (lo_s[j]), .cout (lo_s[j+1])
    );
    sen_sqrt_cell #(.BIT(RB - 1 - j)) u_sq (
      .clk (clk), .en (adv), .cin (sq_s[j]), .cout (sq_s[j+1])
    );
  end

  assign root_sum = (RB+1)'(hi_s[RB].x) + (RB+1)'(lo_s[RB].x);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= (2*RB-1)'(root_sum[RB:2]) * (2*RB-1)'(DIV_M);
      vm_root <= sq_s[RB].r;
      vm_sat1 <= sq_s[RB].sat;
    end
  end

  assign quot = prod[2*RB-2:DIV_S];
  assign tr_sat = |quot[RB-3:OW];

  always_ff @(posedge clk) begin
    if (adv) begin
      unique case (criterion)
        CRIT_TRESCA: begin
          result.saturated <= tr_sat;
          result.equivalent_stress <= tr_sat ? '1 : quot[OW-1:0];
        end
        default: begin
          result.saturated <= vm_sat1;
          result.equivalent_stress <= vm_sat1 ? '1 : vm_root[OW-1:0];
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_sat_all_ones: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |-> result.equivalent_stress == '1)
    else $error("Saturated result is not all ones.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("Result valid right after reset.");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    vld[R1_IDX] && !vm_sat1 |-> vm_root[RB-1:OW] == '0)
    else $error("Square root exceeds the result width.");
`endif

endmodule
